@@ sv/cfwf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfwf_pkg: shared types and constants of the face wetted fraction block
// Quotient format, latencies, control bundle and the face argument table.
// ----------------------------------------------------------------------------
package cfwf_pkg;

	localparam int FRACTION_BITS_DEF = 16;
	localparam int QB                = 30;       // quotient fraction bits (Q1.30)
	localparam int IT_W              = QB + 1;   // intersection width, 0..1.0
	localparam int N_IT              = 12;       // edge intersections per cell
	localparam int N_FACE            = 6;
	localparam int OUT_W             = 17;
	localparam int SETUP_LAT         = 4;
	localparam int DIV_LAT           = QB + 1;
	localparam int FACE_LAT          = 2;
	localparam int TOTAL_LAT         = SETUP_LAT + DIV_LAT + FACE_LAT;

	typedef enum logic [2:0] {
		K_ZERO = 3'b001,
		K_ONE  = 3'b010,
		K_DIV  = 3'b100
	} kind_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic xpos;
		logic p9;
		logic p10;
		logic p11;
	} ctl_t;

	// Arguments p, q, u, v, w, x, y, z of each face; faces are early x, y, z
	// followed by late x, y, z.
	localparam logic [3:0] FACE_ARG [N_FACE][8] = '{
		'{4'd1, 4'd2, 4'd5, 4'd2, 4'd1, 4'd8,  4'd8,  4'd5},
		'{4'd0, 4'd2, 4'd4, 4'd2, 4'd0, 4'd7,  4'd7,  4'd4},
		'{4'd0, 4'd1, 4'd3, 4'd1, 4'd0, 4'd6,  4'd6,  4'd3},
		'{4'd3, 4'd4, 4'd4, 4'd9, 4'd3, 4'd11, 4'd9,  4'd11},
		'{4'd5, 4'd6, 4'd6, 4'd10, 4'd5, 4'd9, 4'd9,  4'd10},
		'{4'd7, 4'd8, 4'd8, 4'd11, 4'd7, 4'd10, 4'd11, 4'd10}
	};

	// Width that holds both fraction * normal sum and a normal << fraction bits.
	function automatic int calc_w(input int fb);
		return (fb + 16 > 35) ? fb + 16 : 35;
	endfunction

	function automatic logic [15:0] abs16(input logic [15:0] v);
		return v[15] ? 16'(-v) : v;
	endfunction

endpackage
`default_nettype wire

@@ sv/cfwf_setup.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfwf_setup: front stages of the face wetted fraction pipeline
// Forms |n|, alpha and the remainders, then the twelve division requests.
// ----------------------------------------------------------------------------
module cfwf_setup import cfwf_pkg::*; #(
	parameter int FB = FRACTION_BITS_DEF,
	parameter int W  = calc_w(FB)
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [18:0]  fraction,
	input  wire logic [15:0]  normal_x,
	input  wire logic [15:0]  normal_y,
	input  wire logic [15:0]  normal_z,
	output ctl_t              ctl,
	output kind_t             kind [N_IT],
	output logic [W-1:0]      num  [N_IT],
	output logic [W-1:0]      den  [N_IT]
);

	ctl_t          ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [17:0]   f_s1;
	logic [15:0]   n_s1  [3];
	logic [W-1:0]  a_s2, a_s3;
	logic [W-1:0]  n_s2  [3];
	logic [W-1:0]  n_s3  [3];
	logic [W-1:0]  av_s3 [3];
	logic [2:0]    lt_s3;
	logic [34:0]   prod;
	logic [16:0]   nsum;
	logic          full1;
	kind_t         kind_c [N_IT];
	logic [W-1:0]  num_c  [N_IT];
	logic [W-1:0]  den_c  [N_IT];
	logic [2:0]    pf_c;
	kind_t         kind_s4 [N_IT];
	logic [W-1:0]  num_s4  [N_IT];
	logic [W-1:0]  den_s4  [N_IT];

	assign full1 = !fraction[18] &&
		({{(FB + 1){1'b0}}, fraction} >= ((FB + 20)'(1) << FB));

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1.full  <= full1;
			ctl_s1.empty <= fraction[18] || (fraction == 19'd0);
			ctl_s1.xpos  <= !normal_x[15] && (normal_x != 16'd0);
			ctl_s1.p9    <= 1'b0;
			ctl_s1.p10   <= 1'b0;
			ctl_s1.p11   <= 1'b0;
			f_s1         <= fraction[17:0];
			n_s1[0]      <= abs16(normal_x);
			n_s1[1]      <= abs16(normal_y);
			n_s1[2]      <= abs16(normal_z);
		end
	end

	assign nsum = 17'(n_s1[0]) + 17'(n_s1[1]) + 17'(n_s1[2]);
	assign prod = 35'(f_s1) * 35'(nsum);

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl_s1;
			a_s2   <= W'(prod);
			for (int i = 0; i < 3; i++) begin
				n_s2[i] <= W'(n_s1[i]) << FB;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s3 <= ctl_s2;
			a_s3   <= a_s2;
			for (int i = 0; i < 3; i++) begin
				n_s3[i]  <= n_s2[i];
				lt_s3[i] <= n_s2[i] < a_s2;
				av_s3[i] <= a_s2 - n_s2[i];
			end
		end
	end

	// Per axis group g: the near edge, the edges beyond it over axes g+1 and g-1,
	// and the far edge, present only when the remainder exceeds the normal of g+1.
	always_comb begin
		int j, k;
		for (int g = 0; g < 3; g++) begin
			j = (g == 2) ? 0 : g + 1;
			k = (g == 0) ? 2 : g - 1;
			kind_c[g]     = lt_s3[g] ? K_ONE : K_DIV;
			num_c[g]      = a_s3;
			den_c[g]      = n_s3[g];
			kind_c[3+2*g] = !lt_s3[g] ? K_ZERO :
				(n_s3[j] >= av_s3[g]) ? K_DIV : K_ONE;
			num_c[3+2*g]  = av_s3[g];
			den_c[3+2*g]  = n_s3[j];
			pf_c[g]       = lt_s3[g] && (n_s3[j] < av_s3[g]);
			kind_c[9+g]   = pf_c[g] ? K_DIV : K_ZERO;
			num_c[9+g]    = av_s3[g] - n_s3[j];
			den_c[9+g]    = n_s3[k];
			kind_c[4+2*g] = !lt_s3[g] ? K_ZERO :
				(n_s3[k] >= av_s3[g]) ? K_DIV : K_ONE;
			num_c[4+2*g]  = av_s3[g];
			den_c[4+2*g]  = n_s3[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4 <= {ctl_s3.full, ctl_s3.empty, ctl_s3.xpos, pf_c[0], pf_c[1], pf_c[2]};
			for (int i = 0; i < N_IT; i++) begin
				kind_s4[i] <= kind_c[i];
				num_s4[i]  <= num_c[i];
				den_s4[i]  <= den_c[i];
			end
		end
	end

	assign ctl  = ctl_s4;
	assign kind = kind_s4;
	assign num  = num_s4;
	assign den  = den_s4;

endmodule
`default_nettype wire

@@ sv/cfwf_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfwf_div: pipelined fractional divider
// One quotient bit per stage; a division saturates at 1.0 and gives 0 on a zero divisor.
// ----------------------------------------------------------------------------
module cfwf_div import cfwf_pkg::*; #(
	parameter int W = calc_w(FRACTION_BITS_DEF)
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire kind_t           kind,
	input  wire logic [W-1:0]    num,
	input  wire logic [W-1:0]    den,
	output logic [IT_W-1:0]      quo
);

	logic [W-1:0]  rem_s [QB+1];
	logic [W-1:0]  den_s [QB+1];
	logic [QB-1:0] q_s   [QB+1];
	logic          fix_s [QB+1];
	logic          val_s [QB+1];
	logic [W-1:0]  rem_n [QB+1];
	logic [QB-1:0] q_n   [QB+1];
	logic [W:0]    r2;
	logic          ge;
	logic          sat;

	assign sat = (kind == K_DIV) && (den != '0) && (num >= den);

	always_comb begin
		rem_n[0] = num;
		q_n[0]   = '0;
		for (int t = 1; t <= QB; t++) begin
			r2       = {rem_s[t-1], 1'b0};
			ge       = r2 >= {1'b0, den_s[t-1]};
			rem_n[t] = ge ? W'(r2 - {1'b0, den_s[t-1]}) : W'(r2);
			q_n[t]   = {q_s[t-1][QB-2:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= rem_n[0];
			den_s[0] <= den;
			q_s[0]   <= q_n[0];
			fix_s[0] <= (kind != K_DIV) || (den == '0) || (num >= den);
			val_s[0] <= (kind == K_ONE) || sat;
			for (int t = 1; t <= QB; t++) begin
				rem_s[t] <= rem_n[t];
				den_s[t] <= den_s[t-1];
				q_s[t]   <= q_n[t];
				fix_s[t] <= fix_s[t-1];
				val_s[t] <= val_s[t-1];
			end
		end
	end

	assign quo = fix_s[QB] ? {val_s[QB], {QB{1'b0}}} : {1'b0, q_s[QB]};

endmodule
`default_nettype wire

@@ sv/cfwf_face.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cfwf_face: face area stages
// Half products and half sums per face, then case selection, clamp and
// near/far assignment into the output register.
// ----------------------------------------------------------------------------
module cfwf_face import cfwf_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [IT_W-1:0]  it [N_IT],
	input  wire ctl_t             ctl,
	output logic [OUT_W-1:0]      near_x,
	output logic [OUT_W-1:0]      near_y,
	output logic [OUT_W-1:0]      near_z,
	output logic [OUT_W-1:0]      far_x,
	output logic [OUT_W-1:0]      far_y,
	output logic [OUT_W-1:0]      far_z
);

	localparam logic [IT_W-1:0] QONE = IT_W'(1) << QB;

	logic [IT_W-1:0]    hp1_c [N_FACE];
	logic [IT_W-1:0]    hp2_c [N_FACE];
	logic [IT_W-1:0]    hs1_c [N_FACE];
	logic [IT_W-1:0]    hs2_c [N_FACE];
	logic [IT_W-1:0]    hp1_s1 [N_FACE];
	logic [IT_W-1:0]    hp2_s1 [N_FACE];
	logic [IT_W-1:0]    hs1_s1 [N_FACE];
	logic [IT_W-1:0]    hs2_s1 [N_FACE];
	logic [N_FACE-1:0]  pge_s1, qge_s1, one_s1, zero_s1;
	ctl_t               ctl_s1;
	logic [IT_W-1:0]    area [N_FACE];
	logic [OUT_W-1:0]   fo   [N_FACE];
	logic [2*IT_W-1:0]  pr1, pr2;
	logic [IT_W:0]      sm1, sm2;

	always_comb begin
		for (int f = 0; f < N_FACE; f++) begin
			pr1      = (2*IT_W)'(it[FACE_ARG[f][0]]) * (2*IT_W)'(it[FACE_ARG[f][1]]);
			pr2      = (2*IT_W)'(it[FACE_ARG[f][6]]) * (2*IT_W)'(it[FACE_ARG[f][7]]);
			sm1      = (IT_W+1)'(it[FACE_ARG[f][2]]) + (IT_W+1)'(it[FACE_ARG[f][3]]);
			sm2      = (IT_W+1)'(it[FACE_ARG[f][4]]) + (IT_W+1)'(it[FACE_ARG[f][5]]);
			hp1_c[f] = pr1[QB+1 +: IT_W];
			hp2_c[f] = pr2[QB+1 +: IT_W];
			hs1_c[f] = sm1[IT_W:1];
			hs2_c[f] = sm2[IT_W:1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl;
			for (int f = 0; f < N_FACE; f++) begin
				hp1_s1[f] <= hp1_c[f];
				hp2_s1[f] <= hp2_c[f];
				hs1_s1[f] <= hs1_c[f];
				hs2_s1[f] <= hs2_c[f];
				pge_s1[f] <= it[FACE_ARG[f][0]][QB];
				qge_s1[f] <= it[FACE_ARG[f][1]][QB];
			end
			one_s1  <= {3'b000, ctl.p9, ctl.p11, ctl.p10};
			zero_s1 <= {!it[2][QB], !it[1][QB], !it[0][QB], 3'b000};
		end
	end

	always_comb begin
		for (int f = 0; f < N_FACE; f++) begin
			priority if (one_s1[f])                   area[f] = QONE;
			else if (zero_s1[f])                      area[f] = '0;
			else if (!pge_s1[f] && !qge_s1[f])        area[f] = hp1_s1[f];
			else if (pge_s1[f] && !qge_s1[f])         area[f] = hs1_s1[f];
			else if (!pge_s1[f] && qge_s1[f])         area[f] = hs2_s1[f];
			else                                      area[f] = QONE - hp2_s1[f];
			if (area[f] > QONE) begin
				area[f] = QONE;
			end
			fo[f] = area[f][QB -: OUT_W];
			if (ctl_s1.full) begin
				fo[f] = OUT_W'(1) << (OUT_W - 1);
			end else if (ctl_s1.empty) begin
				fo[f] = '0;
			end
		end
	end

	// Swap near and far unless the x normal is strictly positive.
	always_ff @(posedge clk) begin
		if (en) begin
			near_x <= ctl_s1.xpos ? fo[0] : fo[3];
			near_y <= ctl_s1.xpos ? fo[1] : fo[4];
			near_z <= ctl_s1.xpos ? fo[2] : fo[5];
			far_x  <= ctl_s1.xpos ? fo[3] : fo[0];
			far_y  <= ctl_s1.xpos ? fo[4] : fo[1];
			far_z  <= ctl_s1.xpos ? fo[5] : fo[2];
		end
	end

endmodule
`default_nettype wire

@@ sv/cell_face_wetted_fraction.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cell_face_wetted_fraction: wetted fraction of the six faces of one cell
// Input stream carries fraction and interface normal; output stream carries
// near and far face wetted fractions per axis in Q1.16.
//
// Usage:
//   s_* channel takes one cell per transfer; m_* channel gives one result
//   per cell, in order. Both follow the valid/ready rule.
//   Throughput is one cell per cycle while m_tready does not stall the
//   output. An input transfer reaches m_tvalid through four setup stages
//   (magnitudes, alpha, remainders, division requests), 31 stages of the
//   twelve parallel dividers (one quotient bit per stage after the first), one
//   stage of face products, and the output register.
//   When the receiver holds m_tready low with a result waiting, the whole
//   pipeline freezes and s_tready drops; nothing is lost or repeated, and a
//   new cell is still taken while the output register is empty.
//   Reset clears all stage valid bits, so s_tready is high and a cell can
//   be taken as soon as reset is released.
// ----------------------------------------------------------------------------
module cell_face_wetted_fraction import cfwf_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [71:0]   s_tdata,   // fraction[18:0], normal_x, normal_y, normal_z
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [103:0]       m_tdata    // near_x, near_y, near_z, far_x, far_y, far_z
);

	localparam int W = calc_w(FRACTION_BITS);

	logic                 en;
	logic [TOTAL_LAT-1:0] vld_q;
	ctl_t                 ctl_setup;
	ctl_t                 ctl_dly_q [DIV_LAT];
	kind_t                kind [N_IT];
	logic [W-1:0]         num  [N_IT];
	logic [W-1:0]         den  [N_IT];
	logic [IT_W-1:0]      it   [N_IT];
	logic [OUT_W-1:0]     near_x, near_y, near_z, far_x, far_y, far_z;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[TOTAL_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[TOTAL_LAT-2:0], s_tvalid};
		end
	end

	cfwf_setup #(.FB(FRACTION_BITS), .W(W)) u_setup (
		.clk      (clk),
		.en       (en),
		.fraction (s_tdata[18:0]),
		.normal_x (s_tdata[34:19]),
		.normal_y (s_tdata[50:35]),
		.normal_z (s_tdata[66:51]),
		.ctl      (ctl_setup),
		.kind     (kind),
		.num      (num),
		.den      (den)
	);

	for (genvar i = 0; i < N_IT; i++) begin : g_div
		cfwf_div #(.W(W)) u_div (
			.clk  (clk),
			.en   (en),
			.kind (kind[i]),
			.num  (num[i]),
			.den  (den[i]),
			.quo  (it[i])
		);
	end

	// Hold the control bundle alongside the divider stages.
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_dly_q[0] <= ctl_setup;
			for (int t = 1; t < DIV_LAT; t++) begin
				ctl_dly_q[t] <= ctl_dly_q[t-1];
			end
		end
	end

	cfwf_face u_face (
		.clk    (clk),
		.en     (en),
		.it     (it),
		.ctl    (ctl_dly_q[DIV_LAT-1]),
		.near_x (near_x),
		.near_y (near_y),
		.near_z (near_z),
		.far_x  (far_x),
		.far_y  (far_y),
		.far_z  (far_z)
	);

	assign m_tdata = {2'b00, far_z, far_y, far_x, near_z, near_y, near_x};

endmodule
`default_nettype wire

@@ test/cell_face_wetted_fraction_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cell_face_wetted_fraction_test: self-checking bench for the face wetted fraction block
// Drives cells with random gaps, stalls the result stream at random and
// compares each result with a bit-exact predictor of the six face fractions.
// ----------------------------------------------------------------------------
module cell_face_wetted_fraction_test;
	import cfwf_pkg::*;

	localparam longint unsigned ONE_Q = 64'd1 << 30;
	localparam int WATCH_LIMIT = 20000;

	typedef struct packed {
		logic signed [15:0] nz;
		logic signed [15:0] ny;
		logic signed [15:0] nx;
		logic signed [18:0] frac;
	} cell_t;

	class wetted_board;
		logic [101:0] pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function longint unsigned quot(longint unsigned num, longint unsigned den);
			longint unsigned q, r;
			q = 0;
			r = num;
			if (den == 0) return 0;
			if (num >= den) return ONE_Q;
			for (int i = 0; i < 30; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= den) begin
					r = r - den;
					q = q | 1;
				end
			end
			return q;
		endfunction

		function longint unsigned area(longint unsigned p, longint unsigned q,
				longint unsigned u, longint unsigned v, longint unsigned w,
				longint unsigned x, longint unsigned y, longint unsigned z);
			if (p < ONE_Q && q < ONE_Q) return (p * q) >> 31;
			if (p >= ONE_Q && q < ONE_Q) return (u + v) >> 1;
			if (p < ONE_Q && q >= ONE_Q) return (w + x) >> 1;
			return ONE_Q - ((y * z) >> 31);
		endfunction

		function logic [16:0] to_q16(longint unsigned v);
			if (v > ONE_Q) v = ONE_Q;
			return 17'(v >> 14);
		endfunction

		function void note_cell(cell_t c);
			longint signed f;
			longint unsigned n0, n1, n2, a, av, k0, k1, k2;
			longint unsigned it[12];
			longint unsigned e[3], l[3];
			logic p9, p10, p11, xpos;
			logic [16:0] o[6];
			f = c.frac;
			xpos = c.nx > 0;
			p9 = 0; p10 = 0; p11 = 0;
			if (f >= 65536 || f <= 0) begin
				for (int d = 0; d < 6; d++) o[d] = (f > 0) ? 17'd65536 : 17'd0;
			end else begin
				n0 = (c.nx < 0) ? -longint'(c.nx) : c.nx;
				n1 = (c.ny < 0) ? -longint'(c.ny) : c.ny;
				n2 = (c.nz < 0) ? -longint'(c.nz) : c.nz;
				a = f * (n0 + n1 + n2);
				k0 = n0 << 16; k1 = n1 << 16; k2 = n2 << 16;
				for (int d = 0; d < 12; d++) it[d] = 0;
				if (k0 >= a) it[0] = quot(a, k0);
				else begin
					it[0] = ONE_Q; av = a - k0;
					if (k1 >= av) it[3] = quot(av, k1);
					else begin it[3] = ONE_Q; it[9] = quot(av - k1, k2); p9 = 1; end
					it[4] = (k2 >= av) ? quot(av, k2) : ONE_Q;
				end
				if (k1 >= a) it[1] = quot(a, k1);
				else begin
					it[1] = ONE_Q; av = a - k1;
					if (k2 >= av) it[5] = quot(av, k2);
					else begin it[5] = ONE_Q; it[10] = quot(av - k2, k0); p10 = 1; end
					it[6] = (k0 >= av) ? quot(av, k0) : ONE_Q;
				end
				if (k2 >= a) it[2] = quot(a, k2);
				else begin
					it[2] = ONE_Q; av = a - k2;
					if (k0 >= av) it[7] = quot(av, k0);
					else begin it[7] = ONE_Q; it[11] = quot(av - k0, k1); p11 = 1; end
					it[8] = (k1 >= av) ? quot(av, k1) : ONE_Q;
				end
				e[0] = p10 ? ONE_Q : area(it[1], it[2], it[5], it[2], it[1], it[8], it[8], it[5]);
				l[0] = (it[0] < ONE_Q) ? 0 :
					area(it[3], it[4], it[4], it[9], it[3], it[11], it[9], it[11]);
				e[1] = p11 ? ONE_Q : area(it[0], it[2], it[4], it[2], it[0], it[7], it[7], it[4]);
				l[1] = (it[1] < ONE_Q) ? 0 :
					area(it[5], it[6], it[6], it[10], it[5], it[9], it[9], it[10]);
				e[2] = p9 ? ONE_Q : area(it[0], it[1], it[3], it[1], it[0], it[6], it[6], it[3]);
				l[2] = (it[2] < ONE_Q) ? 0 :
					area(it[7], it[8], it[8], it[11], it[7], it[10], it[11], it[10]);
				for (int d = 0; d < 3; d++) begin
					o[d]     = to_q16(xpos ? e[d] : l[d]);
					o[d + 3] = to_q16(xpos ? l[d] : e[d]);
				end
			end
			pending.push_back({o[5], o[4], o[3], o[2], o[1], o[0]});
		endfunction

		function void check_faces(logic [103:0] got);
			logic [101:0] want;
			if (pending.size() == 0) begin
				$display("%0t: result with none expected: %h", $time, got);
				errors++;
				return;
			end
			want = pending.pop_front();
			for (int d = 0; d < 6; d++)
				if (got[d*17 +: 17] !== want[d*17 +: 17]) begin
					$display("%0t: face %0d expected %0d actual %0d", $time, d,
						want[d*17 +: 17], got[d*17 +: 17]);
					errors++;
				end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, m_tready = 0;
	logic [71:0] s_tdata = '0;
	logic s_tready, m_tvalid;
	logic [103:0] m_tdata;
	wetted_board board = new();
	bit sent_all = 0;
	int idle_cycles = 0;
	cell_t cells[$];

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	cell_face_wetted_fraction i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	function automatic logic [15:0] pick_normal();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		case ($urandom_range(0, 9))
			0: c.frac = 19'($urandom);
			1: c.frac = 19'sd65536 + 19'($urandom_range(0, 65536));
			2: c.frac = -19'sd65536 + 19'($urandom_range(0, 65536));
			3: c.frac = 19'($urandom_range(1, 8));
			4: c.frac = 19'(65536 - $urandom_range(1, 8));
			default: c.frac = 19'($urandom_range(1, 65535));
		endcase
		c.nx = pick_normal();
		c.ny = pick_normal();
		c.nz = pick_normal();
		return c;
	endfunction

	// drop valid only for a gap, so back-to-back cells keep it high
	task automatic send_cell(cell_t c);
		int gap;
		gap = $urandom_range(0, 7);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {17'd0, c.nz, c.ny, c.nx, c.frac};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_cell(c);
	endtask

	initial begin
		cell_t c;
		// full, empty and extreme-value cells, zero normal, x-normal sign cases
		cells.push_back('{16'sd100, 16'sd100, 16'sd100, 19'sd65536});
		cells.push_back('{16'sd100, 16'sd100, 16'sd100, 19'sd131071});
		cells.push_back('{16'sd100, 16'sd100, 16'sd100, 19'sd0});
		cells.push_back('{16'sd100, 16'sd100, 16'sd100, -19'sd262144});
		cells.push_back('{16'sd0, 16'sd0, 16'sd0, 19'sd30000});
		cells.push_back('{16'sd1, 16'sd2, 16'sd0, 19'sd40000});
		cells.push_back('{16'sd1, 16'sd2, -16'sd3, 19'sd40000});
		cells.push_back('{-16'sd32768, 16'sd32767, 16'sd5, 19'sd1});
		cells.push_back('{16'sd32767, -16'sd32768, -16'sd1, 19'sd65535});
		cells.push_back('{16'sd3, 16'sd3, 16'sd3, 19'sd32768});
		cells.push_back('{16'sd1, 16'sd1, 16'sd30000, 19'sd60000});
		cells.push_back('{16'sd30000, 16'sd1, 16'sd1, 19'sd60000});
		cells.push_back('{16'sd1, 16'sd30000, 16'sd1, 19'sd5000});
		cells.push_back('{16'sd0, 16'sd0, 16'sd7, 19'sd20000});
		cells.push_back('{-16'sd1, -16'sd1, -16'sd1, 19'sd65535});
		cells.push_back('{16'sd0, 16'sd9, 16'sd9, 19'sd50000});
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (cells[i]) send_cell(cells[i]);
		repeat (1100) begin
			c = random_cell();
			send_cell(c);
		end
		s_tvalid <= 0;
		sent_all = 1;
	end

	// stall the result side, with quiet stretches of full throughput
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) board.check_faces(m_tdata);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		@(posedge arst_n);
		while (!(sent_all && board.pending.size() == 0) && idle_cycles < WATCH_LIMIT)
			@(posedge clk);
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("TB_ERROR");
		end else begin
			repeat (TOTAL_LAT + 10) @(posedge clk);
			if (board.errors == 0 && board.pending.size() == 0) $display("TB_OK");
			else $display("TB_ERROR");
		end
		$finish;
	end

endmodule
